// ===== hdl/dllm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Doubly linked list manager package
// Shared defaults, command codes, operation classes and sequencer states.
// ----------------------------------------------------------------------------
package dllm_pkg;

  localparam int NUM_NODES_DEF = 256;
  localparam int NUM_LISTS_DEF = 8;

  typedef enum logic [2:0] {
    MODE_CLEAR      = 3'd0,
    MODE_ADD_TAIL   = 3'd1,
    MODE_ADD_HEAD   = 3'd2,
    MODE_REM_HEAD   = 3'd3,
    MODE_REM_TAIL   = 3'd4,
    MODE_INS_BEFORE = 3'd5,
    MODE_INS_AFTER  = 3'd6,
    MODE_UNLINK     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_REMOVE,
    OP_UNLINK
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_RD2,
    S_WR1,
    S_WR2
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/dllm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dllm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 272,
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/doubly_linked_list_manager.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Doubly linked list manager
// Keeps several sentinel-delimited doubly linked lists over a node pool.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its single result
// beat appears in the cycle after the last busy cycle, marked by done for
// exactly one cycle, and cannot be held off; a new command may be taken in
// the cycle in which done is high. Busy spans S_RD for unlink, S_WR1 and
// S_WR2 for clear, S_RD and S_RD2 for remove, S_RD and S_WR2 for insert
// before or after a reference link, and S_RD, S_RD2 and S_WR2 for add; an
// out of range id drops the command with no busy, yet done still pulses.
// The states follow the dependent reads and the ordered writes through the
// next and prev link memories, each with one write port and a registered
// read. After reset the block sweeps the sentinel entries with busy high.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager
  import dllm_pkg::*;
#(
  parameter int NUM_NODES = NUM_NODES_DEF,
  parameter int NUM_LISTS = NUM_LISTS_DEF,
  localparam int TOTAL_LINKS = NUM_NODES + 2 * NUM_LISTS,
  localparam int LINK_W = $clog2(TOTAL_LINKS + 1),
  localparam int NODE_W = $clog2(NUM_NODES),
  localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        mode,
  input  wire logic [LIST_W-1:0] list_id,
  input  wire logic [NODE_W-1:0] node_id,
  input  wire logic [LINK_W-1:0] ref_link,
  output logic                   done,
  output logic      [NODE_W-1:0] out_node,
  output logic                   node_valid
);

  localparam int RAM_AW = $clog2(TOTAL_LINKS);
  localparam int SENT_W = $clog2(2 * NUM_LISTS);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TOTAL_LINKS);
  localparam logic [LINK_W-1:0] BASE = LINK_W'(NUM_NODES);
  localparam logic [LINK_W-1:0] ONE = LINK_W'(1);
  localparam logic [SENT_W-1:0] LAST_SENT = SENT_W'(2 * NUM_LISTS - 1);

  state_t state, state_next;
  op_t op_q, op_in;
  logic sw_q, sw_in, sw_eff, ref_mem_q, ref_mem_in;
  logic [NODE_W-1:0] node_q;
  logic [LINK_W-1:0] ref_q, e_q, hd_q, q_q, x_q;
  logic [SENT_W-1:0] clr_cnt;
  logic [LINK_W-1:0] h_in, e_in, node_in, node_lq, sent_link, q_next;
  logic need_list, need_node, need_ref, ignore, accept;
  mode_t mode_in;

  logic [LINK_W-1:0] n_raddr, p_raddr, n_waddr, p_waddr, n_wdata, p_wdata;
  logic n_we, p_we;
  logic [LINK_W-1:0] next_raddr, prev_raddr, next_waddr, prev_waddr;
  logic [LINK_W-1:0] next_wdata, prev_wdata;
  logic next_we, prev_we;
  logic [LINK_W-1:0] next_rdata, prev_rdata, next_rd, prev_rd, n_rd, p_rd;
  logic next_rnull, prev_rnull;
  logic done_next, node_valid_next;
  logic [NODE_W-1:0] out_node_next;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign mode_in = mode_t'(mode);

  always_comb begin
    op_in = OP_CLEAR;
    sw_in = 1'b0;
    ref_mem_in = 1'b0;
    need_list = 1'b0;
    need_node = 1'b0;
    need_ref = 1'b0;
    unique case (mode_in)
      MODE_CLEAR: begin
        need_list = 1'b1;
      end
      MODE_ADD_TAIL: begin
        op_in = OP_INSERT;
        sw_in = 1'b1;
        ref_mem_in = 1'b1;
        need_list = 1'b1;
        need_node = 1'b1;
      end
      MODE_ADD_HEAD: begin
        op_in = OP_INSERT;
        ref_mem_in = 1'b1;
        need_list = 1'b1;
        need_node = 1'b1;
      end
      MODE_REM_HEAD: begin
        op_in = OP_REMOVE;
        need_list = 1'b1;
      end
      MODE_REM_TAIL: begin
        op_in = OP_REMOVE;
        sw_in = 1'b1;
        need_list = 1'b1;
      end
      MODE_INS_BEFORE: begin
        op_in = OP_INSERT;
        need_node = 1'b1;
        need_ref = 1'b1;
      end
      MODE_INS_AFTER: begin
        op_in = OP_INSERT;
        sw_in = 1'b1;
        need_node = 1'b1;
        need_ref = 1'b1;
      end
      MODE_UNLINK: begin
        op_in = OP_UNLINK;
        need_node = 1'b1;
      end
      default: begin
        op_in = OP_CLEAR;
      end
    endcase
  end

  assign ignore = (need_list && (32'(list_id) >= NUM_LISTS)) ||
                  (need_node && (32'(node_id) >= NUM_NODES)) ||
                  (need_ref && (ref_link >= NULL_LINK));
  assign h_in = BASE + LINK_W'({list_id, 1'b0});
  assign e_in = sw_in ? (h_in + ONE) : h_in;
  assign node_in = LINK_W'(node_id);
  assign node_lq = LINK_W'(node_q);
  assign sent_link = BASE + LINK_W'(clr_cnt);

  assign next_rd = next_rnull ? NULL_LINK : next_rdata;
  assign prev_rd = prev_rnull ? NULL_LINK : prev_rdata;
  assign n_rd = sw_q ? prev_rd : next_rd;
  assign p_rd = sw_q ? next_rd : prev_rd;
  assign q_next = (ref_q == node_lq) ? node_lq : p_rd;

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (clr_cnt == LAST_SENT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && !ignore) begin
          state_next = (op_in == OP_CLEAR) ? S_WR1 : S_RD;
        end
      end
      S_RD: begin
        case (op_q)
          OP_INSERT: state_next = ref_mem_q ? S_RD2 : S_WR2;
          OP_REMOVE: state_next = S_RD2;
          default:   state_next = S_IDLE;
        endcase
      end
      S_RD2: begin
        state_next = (op_q == OP_INSERT) ? S_WR2 : S_IDLE;
      end
      S_WR1: begin
        state_next = S_WR2;
      end
      S_WR2: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    n_raddr = '0;
    p_raddr = '0;
    n_we = 1'b0;
    p_we = 1'b0;
    n_waddr = '0;
    p_waddr = '0;
    n_wdata = '0;
    p_wdata = '0;
    done_next = 1'b0;
    out_node_next = '0;
    node_valid_next = 1'b0;
    unique case (state)
      S_INIT: begin
        n_we = 1'b1;
        p_we = 1'b1;
        n_waddr = sent_link;
        p_waddr = sent_link;
        if (!clr_cnt[0]) begin
          n_wdata = sent_link + ONE;
          p_wdata = NULL_LINK;
        end else begin
          n_wdata = NULL_LINK;
          p_wdata = sent_link - ONE;
        end
      end
      S_IDLE: begin
        case (mode_in) inside
          MODE_ADD_TAIL, MODE_ADD_HEAD, MODE_REM_HEAD, MODE_REM_TAIL: begin
            n_raddr = e_in;
          end
          MODE_INS_BEFORE, MODE_INS_AFTER: begin
            p_raddr = ref_link;
          end
          MODE_UNLINK: begin
            n_raddr = node_in;
            p_raddr = node_in;
          end
          default: begin
            n_raddr = '0;
          end
        endcase
        done_next = accept && ignore;
      end
      S_RD: begin
        case (op_q)
          OP_INSERT: begin
            if (ref_mem_q) begin
              p_raddr = n_rd;
            end else begin
              n_we = 1'b1;
              n_waddr = node_lq;
              n_wdata = ref_q;
              p_we = 1'b1;
              p_waddr = node_lq;
              p_wdata = p_rd;
            end
          end
          OP_REMOVE: begin
            n_raddr = n_rd;
            p_raddr = n_rd;
          end
          OP_UNLINK: begin
            p_we = 1'b1;
            p_waddr = n_rd;
            p_wdata = p_rd;
            n_we = 1'b1;
            n_waddr = p_rd;
            n_wdata = n_rd;
            done_next = 1'b1;
            out_node_next = node_q;
            node_valid_next = 1'b1;
          end
          default: begin
            done_next = 1'b0;
          end
        endcase
      end
      S_RD2: begin
        if (op_q == OP_INSERT) begin
          n_we = 1'b1;
          n_waddr = node_lq;
          n_wdata = ref_q;
          p_we = 1'b1;
          p_waddr = node_lq;
          p_wdata = p_rd;
        end else begin
          done_next = 1'b1;
          if (n_rd != NULL_LINK) begin
            n_we = 1'b1;
            n_waddr = e_q;
            n_wdata = n_rd;
            p_we = 1'b1;
            p_waddr = n_rd;
            p_wdata = p_rd;
            if (x_q < BASE) begin
              out_node_next = x_q[NODE_W-1:0];
              node_valid_next = 1'b1;
            end
          end
        end
      end
      S_WR1: begin
        n_we = 1'b1;
        n_waddr = hd_q;
        n_wdata = hd_q + ONE;
        p_we = 1'b1;
        p_waddr = hd_q;
        p_wdata = NULL_LINK;
      end
      S_WR2: begin
        done_next = 1'b1;
        n_we = 1'b1;
        p_we = 1'b1;
        if (op_q == OP_CLEAR) begin
          n_waddr = hd_q + ONE;
          n_wdata = NULL_LINK;
          p_waddr = hd_q + ONE;
          p_wdata = hd_q;
        end else begin
          p_waddr = ref_q;
          p_wdata = node_lq;
          n_waddr = q_q;
          n_wdata = node_lq;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Tail-side operations run on the head-side sequence with the two
  // link memories exchanged.
  assign sw_eff = (state == S_IDLE) ? sw_in : sw_q;
  assign next_raddr = sw_eff ? p_raddr : n_raddr;
  assign prev_raddr = sw_eff ? n_raddr : p_raddr;
  assign next_we = sw_eff ? p_we : n_we;
  assign prev_we = sw_eff ? n_we : p_we;
  assign next_waddr = sw_eff ? p_waddr : n_waddr;
  assign prev_waddr = sw_eff ? n_waddr : p_waddr;
  assign next_wdata = sw_eff ? p_wdata : n_wdata;
  assign prev_wdata = sw_eff ? n_wdata : p_wdata;

  dllm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TOTAL_LINKS)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_we && (next_waddr < NULL_LINK)),
    .waddr (next_waddr[RAM_AW-1:0]),
    .wdata (next_wdata),
    .raddr (next_raddr[RAM_AW-1:0]),
    .rdata (next_rdata)
  );

  dllm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TOTAL_LINKS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_we && (prev_waddr < NULL_LINK)),
    .waddr (prev_waddr[RAM_AW-1:0]),
    .wdata (prev_wdata),
    .raddr (prev_raddr[RAM_AW-1:0]),
    .rdata (prev_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      clr_cnt <= '0;
      sw_q <= 1'b0;
      done <= 1'b0;
      out_node <= '0;
      node_valid <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      out_node <= out_node_next;
      node_valid <= node_valid_next;
      if (state == S_INIT) begin
        clr_cnt <= clr_cnt + SENT_W'(1);
      end
      if (accept) begin
        sw_q <= sw_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    next_rnull <= (next_raddr >= NULL_LINK);
    prev_rnull <= (prev_raddr >= NULL_LINK);
    if (accept) begin
      op_q <= op_in;
      ref_mem_q <= ref_mem_in;
      node_q <= node_id;
      ref_q <= ref_link;
      e_q <= e_in;
      hd_q <= h_in;
    end
    if ((state == S_RD) && (op_q == OP_INSERT) && ref_mem_q) begin
      ref_q <= n_rd;
    end
    if ((state == S_RD) && (op_q == OP_REMOVE)) begin
      x_q <= n_rd;
    end
    if (((state == S_RD) && !ref_mem_q) || (state == S_RD2)) begin
      q_q <= q_next;
    end
  end

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither busy nor done");

  a_valid_with_done: assert property (@(posedge clk) disable iff (rst)
    node_valid |-> done)
    else $error("node_valid without done");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(n_we || p_we))
    else $error("link write while idle");

  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !done)
    else $error("result beat during sentinel sweep");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

endmodule
`default_nettype wire

// ===== verif/tb_doubly_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// Doubly linked list manager testbench
// Sends list commands through the start/busy handshake and checks every done
// beat against its expected result: a fixed value for typed directed rows,
// else a predictor that keeps its own copy of the link tables. A short
// directed table comes first. Random traffic follows: mostly well-formed list
// traffic, with out of range references and sentinel misuse mixed in.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import dllm_pkg::*;

  localparam int NODES = NUM_NODES_DEF;
  localparam int LISTS = NUM_LISTS_DEF;
  localparam int LINKS = NODES + 2 * LISTS;
  localparam int NIL = LINKS;
  localparam int ITEM_TARGET = 1650;
  localparam int CALM_TAIL = 300;
  localparam int STALL_LIMIT = 1000;

  typedef logic [8:0] link_t;

  typedef struct {
    mode_t       op;
    logic [2:0]  lst;
    logic [7:0]  node;
    link_t       anchor;
  } list_cmd_t;

  typedef struct {
    logic [7:0] node;
    logic       valid;
  } node_result_t;

  typedef struct {
    list_cmd_t    cmd;
    bit           typed;
    node_result_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] mode;
  logic [2:0] list_id;
  logic [7:0] node_id;
  link_t      ref_link;
  logic       done;
  logic [7:0] out_node;
  logic       node_valid;

  link_t        next_tab [LINKS];
  link_t        prev_tab [LINKS];
  int           owner_of [NODES];
  node_result_t expected_q [$];
  dir_row_t     directed_q [$];
  node_result_t oldest;
  bit           idle_on;
  int           sent_items = 0;
  int           checked = 0;
  int           returned = 0;
  int           errors = 0;
  int           quiet_cycles = 0;

  doubly_linked_list_manager u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .list_id    (list_id),
    .node_id    (node_id),
    .ref_link   (ref_link),
    .done       (done),
    .out_node   (out_node),
    .node_valid (node_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int head_of(int l);
    return NODES + 2 * l;
  endfunction

  function automatic int tail_of(int l);
    return NODES + 2 * l + 1;
  endfunction

  // Links of the null code read as null and writes to it are dropped.
  function automatic link_t read_next(int a);
    if (a < LINKS) return next_tab[a];
    return link_t'(NIL);
  endfunction

  function automatic link_t read_prev(int a);
    if (a < LINKS) return prev_tab[a];
    return link_t'(NIL);
  endfunction

  function automatic void write_next(int a, link_t v);
    if (a < LINKS) next_tab[a] = v;
  endfunction

  function automatic void write_prev(int a, link_t v);
    if (a < LINKS) prev_tab[a] = v;
  endfunction

  function automatic void empty_list(int l);
    int h;
    h = head_of(l);
    next_tab[h] = link_t'(h + 1);
    prev_tab[h] = link_t'(NIL);
    next_tab[h + 1] = link_t'(NIL);
    prev_tab[h + 1] = link_t'(h);
  endfunction

  function automatic void splice_before(int anchor, int n);
    write_next(n, link_t'(anchor));
    write_prev(n, read_prev(anchor));
    write_prev(anchor, link_t'(n));
    write_next(int'(read_prev(n)), link_t'(n));
  endfunction

  function automatic void splice_after(int anchor, int n);
    write_next(n, read_next(anchor));
    write_prev(n, link_t'(anchor));
    write_next(anchor, link_t'(n));
    write_prev(int'(read_next(n)), link_t'(n));
  endfunction

  function automatic node_result_t apply_list_op(list_cmd_t c);
    node_result_t res;
    int h;
    int t;
    int n;
    int r;
    int x;
    int y;
    int taken;
    bit hit;
    res.node = '0;
    res.valid = 1'b0;
    hit = 1'b0;
    taken = 0;
    n = int'(c.node);
    r = int'(c.anchor);
    if ((c.op == MODE_INS_BEFORE || c.op == MODE_INS_AFTER) && r >= LINKS) return res;
    h = head_of((c.op <= MODE_REM_TAIL) ? int'(c.lst) : 0);
    t = h + 1;
    case (c.op)
      MODE_CLEAR: empty_list(int'(c.lst));
      MODE_ADD_TAIL: splice_after(int'(read_prev(t)), n);
      MODE_ADD_HEAD: splice_before(int'(read_next(h)), n);
      MODE_REM_HEAD: begin
        x = int'(read_next(h));
        y = int'(read_next(x));
        if (y != NIL) begin
          write_next(h, link_t'(y));
          write_prev(y, read_prev(x));
          taken = x;
          hit = 1'b1;
        end
      end
      MODE_REM_TAIL: begin
        x = int'(read_prev(t));
        y = int'(read_prev(x));
        if (y != NIL) begin
          write_prev(t, link_t'(y));
          write_next(y, read_next(x));
          taken = x;
          hit = 1'b1;
        end
      end
      MODE_INS_BEFORE: splice_before(r, n);
      MODE_INS_AFTER: splice_after(r, n);
      default: begin
        write_prev(int'(read_next(n)), read_prev(n));
        write_next(int'(read_prev(n)), read_next(n));
        taken = n;
        hit = 1'b1;
      end
    endcase
    if (hit && taken < NODES) begin
      res.node = taken[7:0];
      res.valid = 1'b1;
    end
    return res;
  endfunction

  // Keeps track of which list holds each node so that random traffic only
  // unlinks listed nodes and only inserts free ones.
  function automatic void track_owner(list_cmd_t c, node_result_t got);
    int a;
    a = int'(c.anchor);
    case (c.op)
      MODE_CLEAR: begin
        for (int n = 0; n < NODES; n++) begin
          if (owner_of[n] == int'(c.lst)) owner_of[n] = -1;
        end
      end
      MODE_ADD_TAIL, MODE_ADD_HEAD: owner_of[c.node] = int'(c.lst);
      MODE_REM_HEAD, MODE_REM_TAIL: begin
        if (got.valid) owner_of[got.node] = -1;
      end
      MODE_INS_BEFORE, MODE_INS_AFTER: begin
        if (a < NODES) owner_of[c.node] = owner_of[a];
        else if (a < LINKS) owner_of[c.node] = (a - NODES) / 2;
      end
      default: owner_of[c.node] = -1;
    endcase
  endfunction

  function automatic int count_free();
    int cnt;
    cnt = 0;
    for (int n = 0; n < NODES; n++) begin
      if (owner_of[n] < 0) cnt++;
    end
    return cnt;
  endfunction

  function automatic int pick_node(bit want_free);
    int n;
    do begin
      n = $urandom_range(0, NODES - 1);
    end while ((owner_of[n] < 0) != want_free);
    return n;
  endfunction

  function automatic void row(mode_t op, int l, int n, int a, bit typed, int wn, bit wv);
    dir_row_t d;
    d.cmd.op = op;
    d.cmd.lst = l[2:0];
    d.cmd.node = n[7:0];
    d.cmd.anchor = a[8:0];
    d.typed = typed;
    d.want.node = wn[7:0];
    d.want.valid = wv;
    directed_q.push_back(d);
  endfunction

  task automatic send_cmd(input list_cmd_t c, input bit typed, input node_result_t want);
    node_result_t pred;
    start <= 1'b1;
    mode <= c.op;
    list_id <= c.lst;
    node_id <= c.node;
    ref_link <= c.anchor;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = apply_list_op(c);
    track_owner(c, pred);
    expected_q.push_back(typed ? want : pred);
    sent_items++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, got node %0d valid %0b",
                 $time, out_node, node_valid);
        errors++;
      end else begin
        oldest = expected_q.pop_front();
        checked++;
        if (node_valid) returned++;
        if (out_node !== oldest.node) begin
          $display("%0t: out_node expected %0d, got %0d", $time, oldest.node, out_node);
          errors++;
        end
        if (node_valid !== oldest.valid) begin
          $display("%0t: node_valid expected %0b, got %0b", $time, oldest.valid, node_valid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_q.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    list_cmd_t    c;
    node_result_t none;
    int           nfree;
    int           dice;
    int           l;
    int           kind;
    int           directed_count;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_CLEAR;
    list_id <= '0;
    node_id <= '0;
    ref_link <= '0;
    none.node = '0;
    none.valid = 1'b0;
    for (int n = 0; n < NODES; n++) begin
      next_tab[n] = '0;
      prev_tab[n] = '0;
      owner_of[n] = -1;
    end
    for (int k = 0; k < LISTS; k++) empty_list(k);

    row(MODE_REM_HEAD, 0, 0, 0, 1, 0, 0);
    row(MODE_REM_TAIL, 7, 255, 511, 1, 0, 0);
    row(MODE_ADD_TAIL, 0, 0, 0, 1, 0, 0);
    row(MODE_ADD_TAIL, 0, 255, 0, 1, 0, 0);
    row(MODE_ADD_HEAD, 0, 1, 0, 1, 0, 0);
    row(MODE_INS_BEFORE, 5, 2, 0, 1, 0, 0);
    row(MODE_INS_AFTER, 2, 3, 255, 1, 0, 0);
    row(MODE_INS_AFTER, 0, 4, head_of(7), 1, 0, 0);
    row(MODE_INS_BEFORE, 0, 5, tail_of(7), 1, 0, 0);
    row(MODE_INS_BEFORE, 0, 6, LINKS, 1, 0, 0);
    row(MODE_INS_AFTER, 7, 7, 511, 1, 0, 0);
    row(MODE_UNLINK, 4, 2, 300, 1, 2, 1);
    row(MODE_REM_HEAD, 0, 0, 0, 0, 0, 0);
    row(MODE_REM_TAIL, 0, 0, 0, 0, 0, 0);
    row(MODE_UNLINK, 0, 255, 0, 1, 255, 1);
    row(MODE_REM_TAIL, 7, 0, 0, 0, 0, 0);
    row(MODE_CLEAR, 7, 0, 0, 1, 0, 0);
    row(MODE_REM_HEAD, 7, 0, 0, 1, 0, 0);
    row(MODE_INS_AFTER, 0, 6, tail_of(3), 1, 0, 0);
    row(MODE_REM_HEAD, 3, 0, 0, 0, 0, 0);
    row(MODE_REM_HEAD, 3, 0, 0, 0, 0, 0);
    row(MODE_CLEAR, 3, 0, 0, 1, 0, 0);
    row(MODE_INS_BEFORE, 0, 8, head_of(2), 1, 0, 0);
    row(MODE_REM_TAIL, 2, 0, 0, 0, 0, 0);
    row(MODE_CLEAR, 2, 0, 0, 1, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    foreach (directed_q[i]) send_cmd(directed_q[i].cmd, directed_q[i].typed, directed_q[i].want);
    directed_count = sent_items;

    while (sent_items < ITEM_TARGET) begin
      idle_on = (sent_items < ITEM_TARGET - CALM_TAIL) && ((sent_items / 80) % 3 != 2);
      nfree = count_free();
      c.lst = 3'($urandom_range(0, 7));
      c.node = 8'($urandom_range(0, 255));
      c.anchor = link_t'($urandom_range(0, 511));
      dice = $urandom_range(0, 99);
      if (dice < 5) begin
        c.op = $urandom_range(0, 1) ? MODE_INS_BEFORE : MODE_INS_AFTER;
        c.anchor = link_t'($urandom_range(LINKS, 511));
        send_cmd(c, 1'b0, none);
      end else if (dice < 8 && nfree > 0) begin
        // Optionally clear the list, insert around a sentinel from the wrong side,
        // drain a little, then rebuild the list with a clear.
        l = $urandom_range(0, LISTS - 1);
        if ($urandom_range(0, 1)) begin
          c.op = MODE_CLEAR;
          c.lst = l[2:0];
          send_cmd(c, 1'b0, none);
        end
        c.node = 8'(pick_node(1'b1));
        if ($urandom_range(0, 1)) begin
          c.op = MODE_INS_AFTER;
          c.anchor = link_t'(tail_of(l));
        end else begin
          c.op = MODE_INS_BEFORE;
          c.anchor = link_t'(head_of(l));
        end
        send_cmd(c, 1'b0, none);
        repeat ($urandom_range(0, 3)) begin
          c.op = $urandom_range(0, 1) ? MODE_REM_HEAD : MODE_REM_TAIL;
          c.lst = l[2:0];
          c.node = 8'($urandom_range(0, 255));
          c.anchor = link_t'($urandom_range(0, 511));
          send_cmd(c, 1'b0, none);
        end
        c.op = MODE_CLEAR;
        c.lst = l[2:0];
        send_cmd(c, 1'b0, none);
      end else if (dice < 10) begin
        c.op = MODE_CLEAR;
        send_cmd(c, 1'b0, none);
      end else if ($urandom_range(1, NODES) <= nfree) begin
        c.node = 8'(pick_node(1'b1));
        kind = $urandom_range(0, 3);
        case (kind)
          0: c.op = MODE_ADD_TAIL;
          1: c.op = MODE_ADD_HEAD;
          2: begin
            c.op = MODE_INS_BEFORE;
            if (nfree < NODES && $urandom_range(0, 1)) c.anchor = link_t'(pick_node(1'b0));
            else c.anchor = link_t'(tail_of(int'(c.lst)));
          end
          default: begin
            c.op = MODE_INS_AFTER;
            if (nfree < NODES && $urandom_range(0, 1)) c.anchor = link_t'(pick_node(1'b0));
            else c.anchor = link_t'(head_of(int'(c.lst)));
          end
        endcase
        send_cmd(c, 1'b0, none);
      end else begin
        kind = $urandom_range(0, 2);
        if (kind == 2 && nfree < NODES) begin
          c.op = MODE_UNLINK;
          c.node = 8'(pick_node(1'b0));
        end else begin
          c.op = (kind == 0) ? MODE_REM_HEAD : MODE_REM_TAIL;
        end
        send_cmd(c, 1'b0, none);
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d commands (%0d directed) over all eight modes, checked %0d results.",
             sent_items, directed_count, checked);
    $display("%0d results carried a node; %0d mismatches seen.", returned, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dllm_pkg.sv
hdl/dllm_ram.sv
hdl/doubly_linked_list_manager.sv
verif/tb_doubly_linked_list_manager.sv
